@@ rtl/fbpa_pkg.sv @@
// Shared types and codes for the fixed block pool allocator.
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int SLOTS_DEFAULT = 256;
    localparam logic [15:0] BLOCK_SIZE_RESET = 16'd64;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [1:0] ST_ALLOCATED   = 2'd0;
    localparam logic [1:0] ST_RELEASED    = 2'd1;
    localparam logic [1:0] ST_OUT_OF_SLOTS = 2'd2;
    localparam logic [1:0] ST_INVALID     = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [7:0] release_slot;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  slot;
        logic [23:0] block_address;
        logic [1:0]  status;
        logic [8:0]  used_count;
    } out_item_t;

endpackage

@@ rtl/fbpa_ctrl.sv @@
// Sequencer, list heads and the two link memories.
`timescale 1ns / 1ps

module fbpa_ctrl
    import fbpa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  in_item_t                      in_data,
    input  logic                          res_free,
    output logic                          res_load,
    output out_item_t                     res_item,
    output logic [$clog2(SLOTS)-1:0]      mul_slot
);

    localparam int SW  = $clog2(SLOTS);
    localparam int LW  = $clog2(SLOTS + 1);
    localparam int XW  = (LW > 8) ? LW : 8;
    localparam int CW  = (LW > 9) ? LW : 9;
    localparam logic [LW-1:0] NIL = LW'(SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_PATCH
    } state_t;

    // next word: {in_use, link}
    logic [LW:0]   next_mem [SLOTS];
    logic [LW-1:0] prev_mem [SLOTS];

    logic [LW:0]   next_rd_reg;
    logic [LW-1:0] prev_rd_reg;

    state_t        state_reg, state_next;
    logic [LW-1:0] free_head_reg, free_head_next;
    logic [LW-1:0] used_head_reg, used_head_next;
    logic [LW-1:0] fresh_reg, fresh_next;
    logic [LW-1:0] busy_reg, busy_next;
    logic          wr2_en_reg, wr2_en_next;

    logic          kind_reg, kind_next;
    logic [7:0]    req_reg, req_next;
    logic          wr2_to_next_reg, wr2_to_next_next;
    logic [SW-1:0] wr2_addr_reg, wr2_addr_next;
    logic [LW-1:0] wr2_data_reg, wr2_data_next;

    logic          rd_en;
    logic [SW-1:0] rd_next_addr, rd_prev_addr;
    logic          next_we, prev_we;
    logic [SW-1:0] next_waddr, prev_waddr;
    logic [LW:0]   next_wdata;
    logic [LW-1:0] prev_wdata;

    logic          in_accept;
    logic [XW-1:0] req_x, hreq_x, alloc_x;
    logic          req_ok;
    logic [SW-1:0] hreq_idx, alloc_idx;
    logic          hreq_live;
    logic          free_valid, used_valid, fresh_left, exhausted;
    logic [LW-1:0] rd_link, pv, alloc_slot;
    logic [LW-1:0] busy_inc, busy_dec;
    logic [CW-1:0] busy_x, busy_inc_x, busy_dec_x;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign rd_en     = in_accept;

    assign req_x  = XW'(in_data.release_slot);
    assign req_ok = req_x < XW'(SLOTS);

    assign free_valid = (free_head_reg != NIL);
    assign used_valid = (used_head_reg != NIL);
    assign fresh_left = (fresh_reg != NIL);
    assign exhausted  = !free_valid && !fresh_left;

    assign rd_next_addr = (in_data.kind == KIND_RELEASE)
                        ? (req_ok ? req_x[SW-1:0] : '0)
                        : (free_valid ? free_head_reg[SW-1:0] : '0);
    assign rd_prev_addr = req_ok ? req_x[SW-1:0] : '0;

    assign hreq_x    = XW'(req_reg);
    assign hreq_idx  = hreq_x[SW-1:0];
    // entries at or above the fill count were never written
    assign hreq_live = (hreq_x < XW'(fresh_reg)) && next_rd_reg[LW];
    assign rd_link   = next_rd_reg[LW-1:0];
    assign pv        = prev_rd_reg;

    assign alloc_slot = free_valid ? free_head_reg : fresh_reg;
    assign alloc_idx  = alloc_slot[SW-1:0];
    assign alloc_x    = XW'(alloc_slot);

    assign busy_inc   = busy_reg + LW'(1);
    assign busy_dec   = busy_reg - LW'(1);
    assign busy_x     = CW'(busy_reg);
    assign busy_inc_x = CW'(busy_inc);
    assign busy_dec_x = CW'(busy_dec);

    always_comb
    begin
        state_next       = state_reg;
        free_head_next   = free_head_reg;
        used_head_next   = used_head_reg;
        fresh_next       = fresh_reg;
        busy_next        = busy_reg;
        wr2_en_next      = wr2_en_reg;
        kind_next        = kind_reg;
        req_next         = req_reg;
        wr2_to_next_next = wr2_to_next_reg;
        wr2_addr_next    = wr2_addr_reg;
        wr2_data_next    = wr2_data_reg;
        next_we          = 1'b0;
        prev_we          = 1'b0;
        next_waddr       = '0;
        prev_waddr       = '0;
        next_wdata       = '0;
        prev_wdata       = '0;
        res_load         = 1'b0;
        res_item         = '0;
        mul_slot         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    kind_next  = in_data.kind;
                    req_next   = in_data.release_slot;
                    state_next = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                    if (kind_reg == KIND_ALLOC)
                    begin
                        if (exhausted)
                        begin
                            res_item.status     = ST_OUT_OF_SLOTS;
                            res_item.used_count = busy_x[8:0];
                        end
                        else
                        begin
                            next_we          = 1'b1;
                            next_waddr       = alloc_idx;
                            next_wdata       = {1'b1, used_head_reg};
                            prev_we          = 1'b1;
                            prev_waddr       = alloc_idx;
                            prev_wdata       = NIL;
                            // old head's back link waits for the second write
                            wr2_en_next      = used_valid;
                            wr2_to_next_next = 1'b0;
                            wr2_addr_next    = used_head_reg[SW-1:0];
                            wr2_data_next    = alloc_slot;
                            if (free_valid)
                                free_head_next = rd_link;
                            else
                                fresh_next = fresh_reg + LW'(1);
                            used_head_next      = alloc_slot;
                            busy_next           = busy_inc;
                            res_item.slot       = alloc_x[7:0];
                            res_item.status     = ST_ALLOCATED;
                            res_item.used_count = busy_inc_x[8:0];
                            mul_slot            = alloc_idx;
                            state_next          = S_PATCH;
                        end
                    end
                    else
                    begin
                        if (!hreq_live)
                        begin
                            res_item.slot       = req_reg;
                            res_item.status     = ST_INVALID;
                            res_item.used_count = busy_x[8:0];
                        end
                        else
                        begin
                            next_we          = 1'b1;
                            next_waddr       = hreq_idx;
                            next_wdata       = {1'b0, free_head_reg};
                            prev_we          = (rd_link != NIL);
                            prev_waddr       = rd_link[SW-1:0];
                            prev_wdata       = pv;
                            wr2_en_next      = (pv != NIL);
                            wr2_to_next_next = 1'b1;
                            wr2_addr_next    = pv[SW-1:0];
                            wr2_data_next    = rd_link;
                            if (pv == NIL)
                                used_head_next = rd_link;
                            free_head_next      = hreq_x[LW-1:0];
                            busy_next           = busy_dec;
                            res_item.slot       = req_reg;
                            res_item.status     = ST_RELEASED;
                            res_item.used_count = busy_dec_x[8:0];
                            mul_slot            = hreq_idx;
                            state_next          = S_PATCH;
                        end
                    end
                end
            end

            S_PATCH:
            begin
                if (wr2_en_reg)
                begin
                    if (wr2_to_next_reg)
                    begin
                        next_we    = 1'b1;
                        next_waddr = wr2_addr_reg;
                        next_wdata = {1'b1, wr2_data_reg};
                    end
                    else
                    begin
                        prev_we    = 1'b1;
                        prev_waddr = wr2_addr_reg;
                        prev_wdata = wr2_data_reg;
                    end
                end
                wr2_en_next = 1'b0;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= NIL;
            used_head_reg <= NIL;
            fresh_reg     <= '0;
            busy_reg      <= '0;
            wr2_en_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            used_head_reg <= used_head_next;
            fresh_reg     <= fresh_next;
            busy_reg      <= busy_next;
            wr2_en_reg    <= wr2_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        req_reg         <= req_next;
        wr2_to_next_reg <= wr2_to_next_next;
        wr2_addr_reg    <= wr2_addr_next;
        wr2_data_reg    <= wr2_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_waddr] <= next_wdata;
        if (rd_en)
            next_rd_reg <= next_mem[rd_next_addr];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[prev_waddr] <= prev_wdata;
        if (rd_en)
            prev_rd_reg <= prev_mem[rd_prev_addr];
    end

endmodule

@@ rtl/fbpa_out.sv @@
// Block address multiply and output register.
`timescale 1ns / 1ps

module fbpa_out
    import fbpa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  out_item_t                item,
    input  logic [$clog2(SLOTS)-1:0] mul_slot,
    input  logic [15:0]              block_size,
    output logic                     free,
    output logic                     out_valid,
    input  logic                     out_stall,
    output out_item_t                out_data
);

    localparam int SW = $clog2(SLOTS);
    localparam int PW = SW + 16;
    localparam int AW = (PW > 24) ? PW : 24;

    logic          out_valid_reg, out_valid_next;
    out_item_t     out_data_reg;
    logic [PW-1:0] product;
    logic [AW-1:0] product_x;
    out_item_t     item_full;

    assign product   = PW'(mul_slot) * PW'(block_size);
    assign product_x = AW'(product);

    always_comb
    begin
        item_full = item;
        if (item.status == ST_ALLOCATED || item.status == ST_RELEASED)
            item_full.block_address = product_x[23:0];
        else
            item_full.block_address = '0;
    end

    assign free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= item_full;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/fixed_block_pool_allocator.sv @@
// Top level of the fixed block pool allocator.
//
//   channel   direction  handshake          beat
//   in        in         in_valid/in_stall   in_item_t (kind, release_slot)
//   out       out        out_valid/out_stall out_item_t (slot, address, status, count)
//   cfg       in         cfg_valid/cfg_ready block_size, 16 bits
//
// One item at a time: allocate and release go through accept with link read,
// update with first link writes and patch with the second write, since each link
// memory has one write port. Out-of-slots and invalid release skip the patch step.
// A full output register holds the update cycle until the beat is taken.
// Async reset; no clearing pass: the fresh-slot count fences unwritten entries.
`timescale 1ns / 1ps

module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [15:0]              block_size_reg, block_size_next;
    logic                     res_free;
    logic                     res_load;
    out_item_t                res_item;
    logic [$clog2(SLOTS)-1:0] mul_slot;

    assign cfg_ready       = 1'b1;
    assign block_size_next = (cfg_valid && cfg_ready) ? cfg_data : block_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            block_size_reg <= BLOCK_SIZE_RESET;
        else
            block_size_reg <= block_size_next;
    end

    fbpa_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .res_free (res_free),
        .res_load (res_load),
        .res_item (res_item),
        .mul_slot (mul_slot)
    );

    fbpa_out #(
        .SLOTS (SLOTS)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (res_load),
        .item       (res_item),
        .mul_slot   (mul_slot),
        .block_size (block_size_reg),
        .free       (res_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

@@ rtl/fbpa_checker.sv @@
// Port-level checks for the fixed block pool allocator, with its bind.
`timescale 1ns / 1ps

module fbpa_checker
    import fbpa_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // one item in flight: input stalls right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accept");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_OUT_OF_SLOTS || out_data.status == ST_INVALID)
        |-> out_data.block_address == '0)
        else $error("address set on failed request");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_OUT_OF_SLOTS |-> out_data.slot == '0)
        else $error("slot set on out-of-slots result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_ALLOCATED |-> out_data.used_count != '0)
        else $error("allocation reported with nothing in use");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);
